[design/bba_pkg.sv]
// Shared types and constants for the buddy block allocator.
// Used by bba_ctrl, bba_dp and buddy_block_allocator_top; no dependencies.
package bba_pkg;

	localparam int unsigned POOL_BYTES_DEF = 4096;
	localparam int unsigned MAX_BLOCKS_DEF = 64;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_NO_MEM    = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] req_size;
		logic [31:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_address;
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_SCAN,
		S_A_CHECK,
		S_A_SPLIT,
		S_A_FIN,
		S_F_SCAN,
		S_F_CHECK,
		S_M_START,
		S_M_SCAN,
		S_M_CHECK,
		S_F_FIN
	} state_t;

	typedef enum logic [1:0] {
		MD_ALLOC_FIND,
		MD_SPLIT,
		MD_FREE_FIND,
		MD_MERGE
	} mode_t;

	typedef struct packed {
		logic       clr;
		logic       load;
		logic       scan_start;
		logic       scan;
		mode_t      mode;
		logic       a_fin;
		logic       f_fin;
		logic       merge_step;
		logic       emit;
		logic [1:0] code;
	} ctrl_t;

	typedef struct packed {
		logic clr_done;
		logic scan_done;
		logic found;
		logic bad_size;
		logic short_tbl;
		logic no_split;
		logic split_done;
		logic can_merge;
	} sts_t;

	// ceil(log2(v)) for v >= 1
	function automatic logic [4:0] ceil_lg16(input logic [15:0] v);
		logic [15:0] m;
		logic [4:0]  r;
		m = v - 16'd1;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (m[i]) r = 5'(i + 1);
		end
		return r;
	endfunction

endpackage

[design/bba_ctrl.sv]
// Sequencer for the buddy block allocator: clearing pass, scans, split and merge steps.
// Depends on bba_pkg; drives bba_dp through ctrl_t and reads sts_t.
module bba_ctrl import bba_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   req_type,
	input  sts_t   sts,
	output ctrl_t  ctrl,
	output logic   busy
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nxt = (req_type == REQ_FREE) ? S_F_SCAN : S_A_SCAN;
			end
			S_A_SCAN: begin
				if (sts.scan_done) state_nxt = S_A_CHECK;
			end
			S_A_CHECK: begin
				if (sts.bad_size || !sts.found || sts.short_tbl) state_nxt = S_IDLE;
				else if (sts.no_split) state_nxt = S_A_FIN;
				else state_nxt = S_A_SPLIT;
			end
			S_A_SPLIT: begin
				if (sts.split_done) state_nxt = S_A_FIN;
			end
			S_A_FIN: state_nxt = S_IDLE;
			S_F_SCAN: begin
				if (sts.scan_done) state_nxt = S_F_CHECK;
			end
			S_F_CHECK: begin
				state_nxt = sts.found ? S_M_START : S_IDLE;
			end
			S_M_START: begin
				state_nxt = sts.can_merge ? S_M_SCAN : S_F_FIN;
			end
			S_M_SCAN: begin
				if (sts.scan_done) state_nxt = S_M_CHECK;
			end
			S_M_CHECK: begin
				state_nxt = sts.found ? S_M_START : S_F_FIN;
			end
			S_F_FIN: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mode = MD_ALLOC_FIND;
		ctrl.code = ST_OK;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: ctrl.clr = 1'b1;
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					ctrl.scan_start = 1'b1;
				end
			end
			S_A_SCAN: begin
				ctrl.scan = 1'b1;
				ctrl.mode = MD_ALLOC_FIND;
			end
			S_A_CHECK: begin
				if (sts.bad_size) begin
					ctrl.emit = 1'b1;
					ctrl.code = ST_BAD_SIZE;
				end else if (!sts.found || sts.short_tbl) begin
					ctrl.emit = 1'b1;
					ctrl.code = ST_NO_MEM;
				end else if (!sts.no_split) begin
					// load the split count
					ctrl.scan_start = 1'b1;
					ctrl.mode = MD_SPLIT;
				end
			end
			S_A_SPLIT: begin
				ctrl.scan = 1'b1;
				ctrl.mode = MD_SPLIT;
			end
			S_A_FIN: begin
				ctrl.a_fin = 1'b1;
				ctrl.emit = 1'b1;
				ctrl.code = ST_OK;
			end
			S_F_SCAN: begin
				ctrl.scan = 1'b1;
				ctrl.mode = MD_FREE_FIND;
			end
			S_F_CHECK: begin
				if (!sts.found) begin
					ctrl.emit = 1'b1;
					ctrl.code = ST_NOT_FOUND;
				end
			end
			S_M_START: begin
				if (sts.can_merge) begin
					ctrl.scan_start = 1'b1;
					ctrl.mode = MD_MERGE;
				end
			end
			S_M_SCAN: begin
				ctrl.scan = 1'b1;
				ctrl.mode = MD_MERGE;
			end
			S_M_CHECK: begin
				if (sts.found) ctrl.merge_step = 1'b1;
			end
			S_F_FIN: begin
				ctrl.f_fin = 1'b1;
				ctrl.emit = 1'b1;
				ctrl.code = ST_OK;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

[design/bba_dp.sv]
// Datapath for the buddy block allocator: block table memory, scan pipeline,
// match logic, split/merge registers and the result register. Depends on bba_pkg.
module bba_dp import bba_pkg::*; #(
	parameter int unsigned POOL_BYTES = POOL_BYTES_DEF,
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  req_t        req,
	input  ctrl_t       ctrl,
	output sts_t        sts,
	output logic        done,
	output res_t        res
);

	localparam int unsigned POOL_LG = $clog2(POOL_BYTES + 1) - 1;
	localparam int unsigned OFF_W   = POOL_LG;
	localparam int unsigned LG_W    = $clog2(POOL_LG + 1);
	localparam int unsigned IDX_W   = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W   = IDX_W + 1;
	localparam int unsigned ENT_W   = 2 + LG_W + OFF_W;
	localparam logic [31:0] POOL_SIZE = 32'(1 << POOL_LG);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BLOCKS - 1);

	logic [ENT_W-1:0] mem [MAX_BLOCKS];

	logic [31:0]      base_q;
	logic [4:0]       want_q;
	logic             bad_q;
	logic [31:0]      foff_q;

	logic [IDX_W-1:0] addr_q;
	logic             issue_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [ENT_W-1:0] rdata_s1;
	logic [IDX_W-1:0] clr_q;

	logic             found_q;
	logic [IDX_W-1:0] tgt_idx_q;
	logic [OFF_W-1:0] tgt_off_q;
	logic [LG_W-1:0]  tgt_lg_q;
	logic [CNT_W-1:0] spare_q;
	logic [LG_W-1:0]  rem_q;

	logic             done_q;
	res_t             res_q;

	logic             e_vld, e_alc;
	logic [LG_W-1:0]  e_lg;
	logic [OFF_W-1:0] e_off;
	logic             proc;
	logic             a_hit, f_hit, m_hit, s_hit;
	logic [OFF_W-1:0] bud_off, new_off;
	logic [LG_W-1:0]  new_lg;
	logic [5:0]       need6;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [ENT_W-1:0] wdata;

	assign e_vld = rdata_s1[ENT_W-1];
	assign e_alc = rdata_s1[ENT_W-2];
	assign e_lg  = rdata_s1[OFF_W+LG_W-1:OFF_W];
	assign e_off = rdata_s1[OFF_W-1:0];

	assign proc    = ctrl.scan & vld_s1;
	assign need6   = 6'(tgt_lg_q) - 6'(want_q);
	assign bud_off = tgt_off_q ^ (OFF_W'(1) << tgt_lg_q);
	assign new_lg  = LG_W'(6'(want_q) + 6'(rem_q) - 6'd1);
	assign new_off = tgt_off_q + (OFF_W'(1) << new_lg);

	assign a_hit = e_vld & ~e_alc & (6'(e_lg) >= 6'(want_q)) & (~found_q | (e_off < tgt_off_q));
	assign f_hit = e_vld & e_alc & (32'(e_off) == foff_q) & ~found_q;
	assign m_hit = e_vld & ~e_alc & (e_off == bud_off) & (e_lg == tgt_lg_q);
	assign s_hit = ~e_vld & (rem_q != '0);

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = '0;
		if (ctrl.clr) begin
			we    = 1'b1;
			waddr = clr_q;
			if (clr_q == '0) wdata = {1'b1, 1'b0, LG_W'(POOL_LG), {OFF_W{1'b0}}};
		end else if (ctrl.a_fin) begin
			we    = 1'b1;
			waddr = tgt_idx_q;
			wdata = {1'b1, 1'b1, LG_W'(want_q), tgt_off_q};
		end else if (ctrl.f_fin) begin
			we    = 1'b1;
			waddr = tgt_idx_q;
			wdata = {1'b1, 1'b0, tgt_lg_q, tgt_off_q};
		end else if (proc && ctrl.mode == MD_SPLIT && s_hit) begin
			// upper half of the current split goes to this free slot
			we    = 1'b1;
			wdata = {1'b1, 1'b0, new_lg, new_off};
		end else if (proc && ctrl.mode == MD_MERGE && m_hit) begin
			// drop the buddy; the survivor is written at the end
			we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			clr_q     <= '0;
			found_q   <= 1'b0;
			spare_q   <= '0;
			rem_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) base_q <= cfg_wdata;
			if (ctrl.clr && clr_q != LAST) clr_q <= clr_q + IDX_W'(1);
			done_q <= ctrl.emit;

			if (ctrl.scan_start) begin
				addr_q  <= '0;
				issue_q <= 1'b1;
				vld_s1  <= 1'b0;
			end else begin
				vld_s1 <= issue_q;
				if (issue_q) begin
					idx_s1 <= addr_q;
					if (addr_q == LAST) issue_q <= 1'b0;
					else addr_q <= addr_q + IDX_W'(1);
				end
			end

			if (ctrl.scan_start) begin
				found_q <= 1'b0;
				spare_q <= '0;
				if (ctrl.mode == MD_SPLIT) rem_q <= LG_W'(need6);
			end else if (proc) begin
				case (ctrl.mode)
					MD_ALLOC_FIND: begin
						if (!e_vld) spare_q <= spare_q + CNT_W'(1);
						if (a_hit) found_q <= 1'b1;
					end
					MD_SPLIT: begin
						if (s_hit) rem_q <= rem_q - LG_W'(1);
					end
					MD_FREE_FIND: begin
						if (f_hit) found_q <= 1'b1;
					end
					MD_MERGE: begin
						if (m_hit) found_q <= 1'b1;
					end
					default: found_q <= found_q;
				endcase
			end
		end
	end

	// request, target block and result registers: lowest-offset free block that fits on allocate, current block on free
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			want_q <= ceil_lg16(req.req_size);
			bad_q  <= (req.req_size == 16'd0) || (32'(req.req_size) > POOL_SIZE);
			foff_q <= req.free_address - base_q;
		end
		if (proc && ((ctrl.mode == MD_ALLOC_FIND && a_hit) ||
				(ctrl.mode == MD_FREE_FIND && f_hit))) begin
			tgt_idx_q <= idx_s1;
			tgt_off_q <= e_off;
			tgt_lg_q  <= e_lg;
		end else if (ctrl.merge_step) begin
			tgt_off_q <= tgt_off_q & ~(OFF_W'(1) << tgt_lg_q);
			tgt_lg_q  <= tgt_lg_q + LG_W'(1);
		end
		if (ctrl.emit) begin
			res_q.status        <= ctrl.code;
			res_q.block_address <= ctrl.a_fin ? (base_q + 32'(tgt_off_q)) : 32'd0;
		end
	end

	assign sts.clr_done   = (clr_q == LAST);
	assign sts.scan_done  = vld_s1 && (idx_s1 == LAST);
	assign sts.found      = found_q;
	assign sts.bad_size   = bad_q;
	assign sts.short_tbl  = (32'(need6) > 32'(spare_q));
	assign sts.no_split   = (need6 == 6'd0);
	assign sts.split_done = (rem_q == '0);
	assign sts.can_merge  = (6'(tgt_lg_q) < 6'(POOL_LG));

	assign done = done_q;
	assign res  = res_q;

endmodule

[design/buddy_block_allocator_top.sv]
// Channel   | signals                 | handshake
// request   | start, busy, req        | taken when start && !busy
// result    | done, res               | one-cycle strobe, no backpressure
// config    | cfg_we, cfg_wdata       | pool_base written when cfg_we
//
// Top level of the buddy block allocator; depends on bba_pkg, bba_ctrl, bba_dp.
// Each table scan reads one entry per cycle from the table memory.
// Allocate takes one scan plus one more when a split is needed. Free takes one
// scan plus one per merge attempt. After reset a clearing pass over the table
// keeps busy high. The result is registered and shows in the cycle after the
// request completes; the receiver cannot stall it.
module buddy_block_allocator_top import bba_pkg::*; #(
	parameter int unsigned POOL_BYTES = POOL_BYTES_DEF,
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        done,
	output res_t        res
);

	ctrl_t ctrl;
	sts_t  sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.ctrl     (ctrl),
		.busy     (busy)
	);

	bba_dp #(
		.POOL_BYTES (POOL_BYTES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.ctrl      (ctrl),
		.sts       (sts),
		.done      (done),
		.res       (res)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	a_emit_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> done)
		else $error("emitted result did not reach the strobe");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status != ST_OK) |-> (res.block_address == 32'd0))
		else $error("failed transaction returned a nonzero address");

endmodule

[sim/tb_buddy_block_allocator_top.sv]
// Testbench for buddy_block_allocator_top: drives alloc/free transactions, predicts
// each result with a behavioral block-table model, and compares every done strobe.
// Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
	localparam int NBLK = bba_pkg::MAX_BLOCKS_DEF;

	bit [31:0]   blk_off [NBLK];
	int unsigned blk_lg [NBLK];
	bit          blk_used [NBLK];
	bit          blk_valid [NBLK];
	bit [31:0]   base;
	int unsigned pool_lg;
	bba_pkg::res_t pending[$];
	int errors;
	bit [31:0] live_addrs[$];

	function new();
		pool_lg = 0;
		while (pool_lg < 30 && (64'd1 << (pool_lg + 1)) <= bba_pkg::POOL_BYTES_DEF)
			pool_lg++;
		base = '0;
		errors = 0;
		foreach (blk_valid[i]) begin
			blk_valid[i] = 0;
			blk_used[i] = 0;
			blk_off[i] = '0;
			blk_lg[i] = 0;
		end
		blk_valid[0] = 1;
		blk_lg[0] = pool_lg;
	endfunction

	function int find_slot();
		for (int i = 0; i < NBLK; i++)
			if (!blk_valid[i]) return i;
		return -1;
	endfunction

	function bba_pkg::res_t allocate(bit [15:0] size);
		bba_pkg::res_t r;
		int unsigned want, spare;
		int best, n;
		r = '0;
		want = 0;
		spare = 0;
		best = -1;
		if (size == 0 || size > (64'd1 << pool_lg)) begin
			r.status = bba_pkg::ST_BAD_SIZE;
			return r;
		end
		while (want < 31 && (32'd1 << want) < size) want++;
		for (int i = 0; i < NBLK; i++) begin
			if (!blk_valid[i]) begin
				spare++;
				continue;
			end
			if (blk_used[i] || blk_lg[i] < want) continue;
			if (best < 0 || blk_off[i] < blk_off[best]) best = i;
		end
		if (best < 0 || blk_lg[best] - want > spare) begin
			r.status = bba_pkg::ST_NO_MEM;
			return r;
		end
		for (int s = blk_lg[best]; s > want; s--) begin
			n = find_slot();
			blk_lg[best] = s - 1;
			blk_valid[n] = 1;
			blk_used[n] = 0;
			blk_lg[n] = s - 1;
			blk_off[n] = blk_off[best] + (32'd1 << (s - 1));
		end
		blk_used[best] = 1;
		r.status = bba_pkg::ST_OK;
		r.block_address = base + blk_off[best];
		live_addrs.push_back(r.block_address);
		return r;
	endfunction

	function bba_pkg::res_t release_block(bit [31:0] addr);
		bba_pkg::res_t r;
		bit [31:0] off, bud_off;
		int cur, bud;
		r = '0;
		off = addr - base;
		cur = -1;
		for (int i = 0; i < NBLK; i++)
			if (blk_valid[i] && blk_used[i] && blk_off[i] == off) begin
				cur = i;
				break;
			end
		if (cur < 0) begin
			r.status = bba_pkg::ST_NOT_FOUND;
			return r;
		end
		blk_used[cur] = 0;
		while (blk_lg[cur] < pool_lg) begin
			bud_off = blk_off[cur] ^ (32'd1 << blk_lg[cur]);
			bud = -1;
			for (int i = 0; i < NBLK; i++)
				if (blk_valid[i] && !blk_used[i] && blk_off[i] == bud_off
						&& blk_lg[i] == blk_lg[cur]) begin
					bud = i;
					break;
				end
			if (bud < 0) break;
			if (bud_off < blk_off[cur]) blk_off[cur] = bud_off;
			blk_lg[cur]++;
			blk_valid[bud] = 0;
			blk_used[bud] = 0;
		end
		for (int i = 0; i < live_addrs.size(); i++)
			if (live_addrs[i] == addr) begin
				live_addrs.delete(i);
				break;
			end
		r.status = bba_pkg::ST_OK;
		return r;
	endfunction

	function void set_base(bit [31:0] b);
		// block addresses move with the base
		foreach (live_addrs[i]) live_addrs[i] = live_addrs[i] - base + b;
		base = b;
	endfunction

	function void note_request(bba_pkg::req_t q);
		if (q.req_type == bba_pkg::REQ_ALLOC) pending.push_back(allocate(q.req_size));
		else pending.push_back(release_block(q.free_address));
	endfunction

	function void check_result(bba_pkg::res_t got);
		bba_pkg::res_t exp;
		if (pending.size() == 0) begin
			$display("%0t: result with nothing expected: status %0d addr %h",
				$time, got.status, got.block_address);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.status !== exp.status) begin
			$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
			errors++;
		end
		if (got.block_address !== exp.block_address) begin
			$display("%0t: block_address expected %h actual %h", $time,
				exp.block_address, got.block_address);
			errors++;
		end
	endfunction
endclass

module tb_buddy_block_allocator_top import bba_pkg::*;;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk, arst_n, start, busy, cfg_we, done;
	logic [31:0] cfg_wdata;
	req_t req;
	res_t res;
	alloc_scoreboard book;
	int cycles;
	int burst_left;

	buddy_block_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .res(res)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (done) book.check_result(res);
	end

	task automatic send(req_t q);
		// random gap between bursts
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		burst_left--;
		req = q;
		start = 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		book.note_request(q);
		@(negedge clk);
		start = 0;
		req = req_t'({$urandom, $urandom});
	endtask

	task automatic alloc_req(bit [15:0] size);
		req_t q;
		q = req_t'({$urandom, $urandom});
		q.req_type = REQ_ALLOC;
		q.req_size = size;
		send(q);
	endtask

	task automatic free_req(bit [31:0] addr);
		req_t q;
		q = req_t'({$urandom, $urandom});
		q.req_type = REQ_FREE;
		q.free_address = addr;
		send(q);
	endtask

	task automatic drain();
		while (book.pending.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
	endtask

	task automatic write_base(bit [31:0] b);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_we <= 0;
		book.set_base(b);
	endtask

	function automatic bit [15:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(1, 4096));
			default: return 16'($urandom_range(1, 64));
		endcase
	endfunction

	task automatic random_phase(int n);
		int idx;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: alloc_req(pick_size());
				5, 6, 7:
					if (book.live_addrs.size() != 0) begin
						idx = $urandom_range(0, book.live_addrs.size() - 1);
						free_req(book.live_addrs[idx]);
					end else free_req($urandom);
				8: free_req(book.base + ($urandom_range(0, 4095) & ~32'hF));
				default: free_req($urandom);
			endcase
		end
	endtask

	initial begin
		book = new();
		cycles = 0;
		burst_left = 0;
		start = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		req = '0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: size extremes, exhaustion, double free, merges
		alloc_req(16'd0);
		alloc_req(16'd4097);
		alloc_req(16'hFFFF);
		alloc_req(16'd4096);
		alloc_req(16'd1);
		free_req(32'd0);
		free_req(32'd0);
		alloc_req(16'd1);
		alloc_req(16'd1);
		alloc_req(16'd3);
		alloc_req(16'd2048);
		free_req(32'd1);
		free_req(32'd4);
		free_req(32'hFFFF_FFFF);
		free_req(32'd2048);
		free_req(32'd0);
		for (int i = 0; i < 13; i++) alloc_req(16'd1);
		alloc_req(16'd1);
		free_req(32'd0);
		drain();

		write_base(32'hFFFF_F800);
		random_phase(400);
		drain();
		write_base(32'h0000_0000);
		random_phase(400);
		drain();
		write_base($urandom);
		random_phase(350);
		drain();
		write_base(32'hFFFF_FFFF);
		random_phase(350);
		drain();

		if (book.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[sim.f]
design/bba_pkg.sv
design/bba_ctrl.sv
design/bba_dp.sv
design/buddy_block_allocator_top.sv
sim/tb_buddy_block_allocator_top.sv
